// ===== rtl/tppfc_pkg.sv =====
package tppfc_pkg;

   localparam int SUM_W   = 56;
   localparam int RMS_W   = 16;
   localparam int HOLD_W  = 17;
   localparam int BASE_W  = 39;
   localparam int DIFF_W  = 18;
   localparam int MAG_W   = 17;
   localparam int SQ_W    = 34;
   localparam int AMP_W   = 16;
   localparam int BAND_W  = 10;
   localparam int WIN_W   = 24;
   localparam int PROD_W  = 57;
   localparam int QUO_W   = 56;
   localparam int REF_W   = 57;
   localparam int CMP_W   = 58;
   localparam int CSR_W   = 24;
   localparam int IDX_W   = 3;
   localparam int STEP_W  = 5;
   localparam int ROOT_W  = 28;
   localparam int SREM_W  = 32;

   localparam int REF_BITS  = 4;
   localparam int REF_STEPS = QUO_W / REF_BITS;
   localparam int RMS_BITS  = 2;
   localparam int RMS_STEPS = QUO_W / RMS_BITS;
   localparam int SQRT_STEPS = QUO_W / 2;

   localparam logic [RMS_W-1:0]  NOMINAL_RMS = 16'd25496;
   localparam logic [HOLD_W-1:0] HOLD_RESET  = 17'd90;

   localparam logic [15:0] TARGET_RESET = 16'd43271;
   localparam logic [15:0] GAIN_RESET   = 16'd6554;
   localparam logic [15:0] LOAD_RESET   = 16'd0;
   localparam logic [9:0]  BAND_RESET   = 10'd10;
   localparam logic [16:0] TICKS_RESET  = 17'd100000;
   localparam logic [23:0] WINDOW_RESET = 24'd50000;
   localparam logic [15:0] LOW_RESET    = 16'd22945;
   localparam logic [15:0] HIGH_RESET   = 16'd28044;

   localparam logic [1:0] SIGN_NONE = 2'd0;
   localparam logic [1:0] SIGN_POS  = 2'd1;
   localparam logic [1:0] SIGN_NEG  = 2'd2;
   localparam logic [1:0] CROSS_MAX = 2'd3;
   localparam logic [1:0] CROSS_MIN = 2'd2;

   typedef enum logic [IDX_W-1:0] {
      REG_TARGET = 3'd0,
      REG_GAIN   = 3'd1,
      REG_LOAD   = 3'd2,
      REG_BAND   = 3'd3,
      REG_TICKS  = 3'd4,
      REG_WINDOW = 3'd5,
      REG_LOW    = 3'd6,
      REG_HIGH   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [BAND_W-1:0] band;
      logic [HOLD_W-1:0] hold_ticks;
      logic [WIN_W-1:0]  min_window;
      logic [RMS_W-1:0]  rms_low;
      logic [RMS_W-1:0]  rms_high;
   } lane_cfg_type;

   typedef struct packed {
      logic             switch_on;
      logic [RMS_W-1:0] rms;
   } lane_res_type;

   typedef enum logic [2:0] {
      L_IDLE,
      L_MUL,
      L_DIV,
      L_RDIV,
      L_SQRT,
      L_SW
   } lane_state_type;

   typedef enum logic [2:0] {
      T_IDLE,
      T_BASE0,
      T_BASE1,
      T_RUN,
      T_OUT
   } top_state_type;

endpackage

// ===== rtl/tppfc_req_if.sv =====
interface tppfc_req_if;
   logic               valid;
   logic               ready;
   logic signed [16:0] volt_a;
   logic signed [16:0] volt_b;
   logic signed [16:0] volt_c;
   logic signed [16:0] volt_out;
   logic signed [15:0] amp_a;
   logic signed [15:0] amp_b;
   logic signed [15:0] amp_c;

   modport source (output valid, volt_a, volt_b, volt_c, volt_out, amp_a, amp_b, amp_c,
                   input ready);
   modport sink (input valid, volt_a, volt_b, volt_c, volt_out, amp_a, amp_b, amp_c,
                 output ready);
endinterface

// ===== rtl/tppfc_rsp_if.sv =====
interface tppfc_rsp_if;
   logic        valid;
   logic        ready;
   logic        switch_a;
   logic        switch_b;
   logic        switch_c;
   logic [15:0] rms_ab;
   logic [15:0] rms_bc;
   logic [15:0] rms_ca;

   modport source (output valid, switch_a, switch_b, switch_c, rms_ab, rms_bc, rms_ca,
                   input ready);
   modport sink (input valid, switch_a, switch_b, switch_c, rms_ab, rms_bc, rms_ca,
                 output ready);
endinterface

// ===== rtl/tppfc_lane.sv =====
module tppfc_lane #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        start,
   input  logic signed [tppfc_pkg::DIFF_W-1:0]         diff,
   input  logic signed [tppfc_pkg::BASE_W-1:0]         base,
   input  logic signed [tppfc_pkg::AMP_W-1:0]          amp,
   input  tppfc_pkg::lane_cfg_type                     cfg,
   output logic                                        done,
   output tppfc_pkg::lane_res_type                     res
);

   localparam int CW   = COUNT_WIDTH;
   localparam int CMPW = (CW > tppfc_pkg::WIN_W) ? CW : tppfc_pkg::WIN_W;

   tppfc_pkg::lane_state_type state_ff, state_in;

   logic signed [tppfc_pkg::DIFF_W-1:0] diff_ff, diff_in;
   logic signed [tppfc_pkg::AMP_W-1:0]  amp_ff, amp_in;
   logic signed [tppfc_pkg::BASE_W-1:0] base_ff, base_in;
   logic [tppfc_pkg::QUO_W-1:0]         quo_ff, quo_in;
   logic [tppfc_pkg::MAG_W-1:0]         rem_ff, rem_in;
   logic                                neg_ff, neg_in;
   logic [tppfc_pkg::SQ_W-1:0]          sq_ff, sq_in;
   logic signed [tppfc_pkg::REF_W-1:0]  ref_ff, ref_in;
   logic [CW:0]                         rrem_ff, rrem_in;
   logic [CW-1:0]                       cdiv_ff, cdiv_in;
   logic [tppfc_pkg::ROOT_W-1:0]        root_ff, root_in;
   logic [tppfc_pkg::SREM_W-1:0]        srem_ff, srem_in;
   logic [tppfc_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [tppfc_pkg::SUM_W-1:0]         sum_ff, sum_in;
   logic [CW-1:0]                       cnt_ff, cnt_in;
   logic [1:0]                          sign_ff, sign_in;
   logic [1:0]                          cross_ff, cross_in;
   logic [tppfc_pkg::RMS_W-1:0]         rms_ff, rms_in;
   logic                                sw_ff, sw_in;
   logic [tppfc_pkg::HOLD_W-1:0]        hold_ff, hold_in;
   logic                                done_ff, done_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tppfc_pkg::L_IDLE;
         sum_ff   <= '0;
         cnt_ff   <= '0;
         sign_ff  <= tppfc_pkg::SIGN_NONE;
         cross_ff <= '0;
         rms_ff   <= tppfc_pkg::NOMINAL_RMS;
         sw_ff    <= 1'b1;
         hold_ff  <= tppfc_pkg::HOLD_RESET;
         done_ff  <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         sum_ff   <= sum_in;
         cnt_ff   <= cnt_in;
         sign_ff  <= sign_in;
         cross_ff <= cross_in;
         rms_ff   <= rms_in;
         sw_ff    <= sw_in;
         hold_ff  <= hold_in;
         done_ff  <= done_in;
         step_ff  <= step_in;
      end
      diff_ff <= diff_in;
      amp_ff  <= amp_in;
      base_ff <= base_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      neg_ff  <= neg_in;
      sq_ff   <= sq_in;
      ref_ff  <= ref_in;
      rrem_ff <= rrem_in;
      cdiv_ff <= cdiv_in;
      root_ff <= root_in;
      srem_ff <= srem_in;
   end

   always_comb begin
      logic [tppfc_pkg::DIFF_W-1:0]       mag_full;
      logic [tppfc_pkg::MAG_W-1:0]        mag;
      logic signed [tppfc_pkg::PROD_W-1:0] prod;
      logic [tppfc_pkg::PROD_W-1:0]       prod_abs;
      logic [tppfc_pkg::RMS_W-1:0]        dv;
      logic [tppfc_pkg::MAG_W-1:0]        r;
      logic [tppfc_pkg::MAG_W-1:0]        t;
      logic [tppfc_pkg::QUO_W-1:0]        q;
      logic [CW:0]                        rr;
      logic [CW:0]                        rt;
      logic [tppfc_pkg::SUM_W:0]          s57;
      logic [tppfc_pkg::SUM_W-1:0]        nsum;
      logic [CW-1:0]                      ncnt;
      logic [1:0]                         sg;
      logic [1:0]                         ncross;
      logic [tppfc_pkg::SREM_W-1:0]       st;
      logic [tppfc_pkg::SREM_W-1:0]       trial;
      logic [tppfc_pkg::ROOT_W-1:0]       nroot;
      logic [tppfc_pkg::HOLD_W-1:0]       h;
      logic signed [tppfc_pkg::CMP_W-1:0] i26;
      logic signed [tppfc_pkg::CMP_W-1:0] bnd;
      logic signed [tppfc_pkg::CMP_W-1:0] rf;
      logic                               upd;

      state_in = state_ff;
      diff_in  = diff_ff;
      amp_in   = amp_ff;
      base_in  = base_ff;
      quo_in   = quo_ff;
      rem_in   = rem_ff;
      neg_in   = neg_ff;
      sq_in    = sq_ff;
      ref_in   = ref_ff;
      rrem_in  = rrem_ff;
      cdiv_in  = cdiv_ff;
      root_in  = root_ff;
      srem_in  = srem_ff;
      step_in  = step_ff;
      sum_in   = sum_ff;
      cnt_in   = cnt_ff;
      sign_in  = sign_ff;
      cross_in = cross_ff;
      rms_in   = rms_ff;
      sw_in    = sw_ff;
      hold_in  = hold_ff;
      done_in  = 1'b0;

      mag_full = diff_ff[tppfc_pkg::DIFF_W-1] ? -diff_ff : diff_ff;
      mag      = mag_full[tppfc_pkg::MAG_W-1:0];
      prod     = base_ff * $signed({1'b0, mag});
      prod_abs = prod[tppfc_pkg::PROD_W-1] ? -prod : prod;
      dv       = (rms_ff == '0) ? tppfc_pkg::RMS_W'(1) : rms_ff;

      r = rem_ff;
      q = quo_ff;
      t = '0;
      rr = rrem_ff;
      rt = '0;
      s57 = '0;
      nsum = '0;
      ncnt = '0;
      sg = tppfc_pkg::SIGN_NONE;
      ncross = cross_ff;
      st = '0;
      trial = '0;
      nroot = root_ff;
      h = '0;
      i26 = '0;
      bnd = '0;
      rf = '0;
      upd = 1'b0;

      case (state_ff)
         tppfc_pkg::L_IDLE: begin
            if (start) begin
               diff_in  = diff;
               amp_in   = amp;
               base_in  = base;
               state_in = tppfc_pkg::L_MUL;
            end
         end
         tppfc_pkg::L_MUL: begin
            neg_in   = prod[tppfc_pkg::PROD_W-1];
            quo_in   = prod_abs[tppfc_pkg::QUO_W-1:0];
            rem_in   = '0;
            sq_in    = mag * mag;
            step_in  = '0;
            state_in = tppfc_pkg::L_DIV;
         end
         tppfc_pkg::L_DIV: begin
            for (int i = 0; i < tppfc_pkg::REF_BITS; i++) begin
               t = {r[tppfc_pkg::RMS_W-1:0], q[tppfc_pkg::QUO_W-1]};
               q = {q[tppfc_pkg::QUO_W-2:0], 1'b0};
               if (t >= {1'b0, dv}) begin
                  r    = t - {1'b0, dv};
                  q[0] = 1'b1;
               end else begin
                  r = t;
               end
            end
            rem_in  = r;
            quo_in  = q;
            step_in = step_ff + 1'b1;
            if (step_ff == tppfc_pkg::STEP_W'(tppfc_pkg::REF_STEPS - 1)) begin
               ref_in  = neg_ff ? -$signed({1'b0, q}) : $signed({1'b0, q});
               s57     = {1'b0, sum_ff} + (tppfc_pkg::SUM_W + 1)'(sq_ff);
               nsum    = s57[tppfc_pkg::SUM_W] ? '1 : s57[tppfc_pkg::SUM_W-1:0];
               ncnt    = (&cnt_ff) ? cnt_ff : cnt_ff + 1'b1;
               sum_in  = nsum;
               cnt_in  = ncnt;
               if (diff_ff != '0) begin
                  sg = diff_ff[tppfc_pkg::DIFF_W-1] ? tppfc_pkg::SIGN_NEG : tppfc_pkg::SIGN_POS;
                  if (sign_ff != sg) begin
                     ncross   = (cross_ff == tppfc_pkg::CROSS_MAX) ? cross_ff : cross_ff + 1'b1;
                     cross_in = ncross;
                     upd = (CMPW'(ncnt) > CMPW'(cfg.min_window)) &&
                           (ncross >= tppfc_pkg::CROSS_MIN) && (ncnt != '0);
                  end
                  sign_in = sg;
               end
               step_in = '0;
               if (upd) begin
                  quo_in   = nsum;
                  cdiv_in  = ncnt;
                  rrem_in  = '0;
                  sum_in   = '0;
                  cnt_in   = '0;
                  state_in = tppfc_pkg::L_RDIV;
               end else begin
                  state_in = tppfc_pkg::L_SW;
               end
            end
         end
         tppfc_pkg::L_RDIV: begin
            for (int i = 0; i < tppfc_pkg::RMS_BITS; i++) begin
               rt = {rr[CW-1:0], q[tppfc_pkg::QUO_W-1]};
               q  = {q[tppfc_pkg::QUO_W-2:0], 1'b0};
               if (rt >= {1'b0, cdiv_ff}) begin
                  rr   = rt - {1'b0, cdiv_ff};
                  q[0] = 1'b1;
               end else begin
                  rr = rt;
               end
            end
            rrem_in = rr;
            quo_in  = q;
            step_in = step_ff + 1'b1;
            if (step_ff == tppfc_pkg::STEP_W'(tppfc_pkg::RMS_STEPS - 1)) begin
               step_in  = '0;
               root_in  = '0;
               srem_in  = '0;
               state_in = tppfc_pkg::L_SQRT;
            end
         end
         tppfc_pkg::L_SQRT: begin
            st    = {srem_ff[tppfc_pkg::SREM_W-3:0], quo_ff[tppfc_pkg::QUO_W-1 -: 2]};
            trial = {2'b00, root_ff, 2'b01};
            if (st >= trial) begin
               srem_in = st - trial;
               nroot   = {root_ff[tppfc_pkg::ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = st;
               nroot   = {root_ff[tppfc_pkg::ROOT_W-2:0], 1'b0};
            end
            root_in = nroot;
            quo_in  = {quo_ff[tppfc_pkg::QUO_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == tppfc_pkg::STEP_W'(tppfc_pkg::SQRT_STEPS - 1)) begin
               if (nroot < tppfc_pkg::ROOT_W'(cfg.rms_low)) begin
                  rms_in = cfg.rms_low;
               end else if (nroot > tppfc_pkg::ROOT_W'(cfg.rms_high)) begin
                  rms_in = cfg.rms_high;
               end else begin
                  rms_in = nroot[tppfc_pkg::RMS_W-1:0];
               end
               step_in  = '0;
               state_in = tppfc_pkg::L_SW;
            end
         end
         tppfc_pkg::L_SW: begin
            i26 = tppfc_pkg::CMP_W'({amp_ff, 16'h0000});
            i26 = {{(tppfc_pkg::CMP_W - 32){amp_ff[tppfc_pkg::AMP_W-1]}}, amp_ff, 16'h0000};
            bnd = $signed({{(tppfc_pkg::CMP_W - tppfc_pkg::BAND_W - 16){1'b0}}, cfg.band, 16'h0000});
            rf  = {ref_ff[tppfc_pkg::REF_W-1], ref_ff};
            h   = hold_ff - 1'b1;
            if (sw_ff && (i26 > rf + bnd)) begin
               h = '0;
            end else if (!sw_ff && (i26 < rf - bnd)) begin
               h = '0;
            end
            if (h == '0) begin
               sw_in   = ~sw_ff;
               hold_in = cfg.hold_ticks;
            end else begin
               hold_in = h;
            end
            done_in  = 1'b1;
            state_in = tppfc_pkg::L_IDLE;
         end
         default: begin
            state_in = tppfc_pkg::L_IDLE;
         end
      endcase
   end

   assign done          = done_ff;
   assign res.switch_on = sw_ff;
   assign res.rms       = rms_ff;

endmodule

// ===== rtl/three_phase_pfc_hysteresis_control_core.sv =====
// Channel  | Direction | Handshake       | Contents
// req_bus  | in        | valid / ready   | three line voltages, output voltage, three currents
// rsp_bus  | out       | valid / ready   | three switch states, three line RMS estimates
// csr_*    | in        | write enable    | eight control registers, index and data
//
// One request at a time: a new one is accepted only after the last is loaded for output. Each
// phase lane runs a four-bit-per-cycle reference divider for every request.
// A request that closes an RMS window also runs the window divider and square root.
// Reset is synchronous and restores the register defaults and the lane state.
// A result waiting in the output register stalls only the end of the next request.
module three_phase_pfc_hysteresis_control_core #(
   parameter int COUNT_WIDTH = 24
) (
   input  logic                             clock,
   input  logic                             reset,
   tppfc_req_if.sink                        req_bus,
   tppfc_rsp_if.source                      rsp_bus,
   input  logic                             csr_write,
   input  logic [tppfc_pkg::IDX_W-1:0]      csr_index,
   input  logic [tppfc_pkg::CSR_W-1:0]      csr_data
);

   tppfc_pkg::top_state_type state_ff, state_in;

   logic [15:0] target_ff, gain_ff, load_ff, low_ff, high_ff;
   logic [9:0]  band_ff;
   logic [16:0] ticks_ff;
   logic [23:0] window_ff;

   logic signed [16:0] va_ff, vb_ff, vc_ff, vo_ff;
   logic signed [15:0] amp_ff [3];
   logic signed [33:0] p1_ff, p1_in;
   logic signed [34:0] p2_ff, p2_in;
   logic signed [tppfc_pkg::BASE_W-1:0] base_ff, base_in;
   logic        start_ff, start_in;
   logic [2:0]  seen_ff, seen_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [2:0]  sw_out_ff;
   logic [15:0] rms_out_ff [3];
   logic        load_out;

   logic signed [tppfc_pkg::DIFF_W-1:0] diff [3];
   logic [2:0]                          lane_done;
   tppfc_pkg::lane_res_type             lane_res [3];
   tppfc_pkg::lane_cfg_type             lane_cfg;
   logic                                accept;

   assign accept        = req_bus.valid && req_bus.ready;
   assign req_bus.ready = (state_ff == tppfc_pkg::T_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         target_ff <= tppfc_pkg::TARGET_RESET;
         gain_ff   <= tppfc_pkg::GAIN_RESET;
         load_ff   <= tppfc_pkg::LOAD_RESET;
         band_ff   <= tppfc_pkg::BAND_RESET;
         ticks_ff  <= tppfc_pkg::TICKS_RESET;
         window_ff <= tppfc_pkg::WINDOW_RESET;
         low_ff    <= tppfc_pkg::LOW_RESET;
         high_ff   <= tppfc_pkg::HIGH_RESET;
      end else if (csr_write) begin
         case (tppfc_pkg::csr_index_type'(csr_index))
            tppfc_pkg::REG_TARGET: target_ff <= csr_data[15:0];
            tppfc_pkg::REG_GAIN:   gain_ff   <= csr_data[15:0];
            tppfc_pkg::REG_LOAD:   load_ff   <= csr_data[15:0];
            tppfc_pkg::REG_BAND:   band_ff   <= csr_data[9:0];
            tppfc_pkg::REG_TICKS:  ticks_ff  <= csr_data[16:0];
            tppfc_pkg::REG_WINDOW: window_ff <= csr_data[23:0];
            tppfc_pkg::REG_LOW:    low_ff    <= csr_data[15:0];
            tppfc_pkg::REG_HIGH:   high_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tppfc_pkg::T_IDLE;
         start_ff     <= 1'b0;
         seen_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         seen_ff      <= seen_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      if (accept) begin
         va_ff     <= req_bus.volt_a;
         vb_ff     <= req_bus.volt_b;
         vc_ff     <= req_bus.volt_c;
         vo_ff     <= req_bus.volt_out;
         amp_ff[0] <= req_bus.amp_a;
         amp_ff[1] <= req_bus.amp_b;
         amp_ff[2] <= req_bus.amp_c;
      end
      p1_ff   <= p1_in;
      p2_ff   <= p2_in;
      base_ff <= base_in;
      if (load_out) begin
         for (int k = 0; k < 3; k++) begin
            sw_out_ff[k]  <= lane_res[k].switch_on;
            rms_out_ff[k] <= lane_res[k].rms;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      start_in     = 1'b0;
      seen_in      = seen_ff | lane_done;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      load_out     = 1'b0;
      p1_in        = vo_ff * $signed({1'b0, load_ff});
      p2_in        = $signed({1'b0, gain_ff}) *
                     ($signed({2'b00, target_ff}) - $signed({vo_ff[16], vo_ff}));
      base_in      = base_ff;

      case (state_ff)
         tppfc_pkg::T_IDLE: begin
            if (accept) begin
               state_in = tppfc_pkg::T_BASE0;
            end
         end
         tppfc_pkg::T_BASE0: begin
            state_in = tppfc_pkg::T_BASE1;
         end
         tppfc_pkg::T_BASE1: begin
            base_in  = tppfc_pkg::BASE_W'(p1_ff) + (tppfc_pkg::BASE_W'(p2_ff) <<< 4);
            start_in = 1'b1;
            seen_in  = '0;
            state_in = tppfc_pkg::T_RUN;
         end
         tppfc_pkg::T_RUN: begin
            if (&(seen_ff | lane_done)) begin
               state_in = tppfc_pkg::T_OUT;
            end
         end
         tppfc_pkg::T_OUT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               load_out     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = tppfc_pkg::T_IDLE;
            end
         end
         default: begin
            state_in = tppfc_pkg::T_IDLE;
         end
      endcase
   end

   assign diff[0] = {va_ff[16], va_ff} - {vb_ff[16], vb_ff};
   assign diff[1] = {vb_ff[16], vb_ff} - {vc_ff[16], vc_ff};
   assign diff[2] = {vc_ff[16], vc_ff} - {va_ff[16], va_ff};

   assign lane_cfg.band       = band_ff;
   assign lane_cfg.hold_ticks = ticks_ff;
   assign lane_cfg.min_window = window_ff;
   assign lane_cfg.rms_low    = low_ff;
   assign lane_cfg.rms_high   = high_ff;

   for (genvar g = 0; g < 3; g++) begin : g_lane
      tppfc_lane #(
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_lane (
         .clock (clock),
         .reset (reset),
         .start (start_ff),
         .diff  (diff[g]),
         .base  (base_ff),
         .amp   (amp_ff[g]),
         .cfg   (lane_cfg),
         .done  (lane_done[g]),
         .res   (lane_res[g])
      );
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.switch_a = sw_out_ff[0];
   assign rsp_bus.switch_b = sw_out_ff[1];
   assign rsp_bus.switch_c = sw_out_ff[2];
   assign rsp_bus.rms_ab   = rms_out_ff[0];
   assign rsp_bus.rms_bc   = rms_out_ff[1];
   assign rsp_bus.rms_ca   = rms_out_ff[2];

endmodule
